@@ src/sth_pkg.sv @@
// Shared types and constants for the sorted table hunt search block.
// No dependencies; every other file imports this package.
package sth_pkg;

   // Defaults for the top-level parameters
   localparam int TABLE_DEPTH_DEF = 256;
   localparam int VALUE_WIDTH_DEF = 32;

   // Fixed field widths
   localparam int CMD_W     = 1;
   localparam int INDEX_W   = 8;
   localparam int FIELD_W   = 32;
   localparam int GUESS_W   = 10;
   localparam int RESULT_W  = 10;
   localparam int LENGTH_W  = 9;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] CSR_TABLE_LENGTH = 1'b0;
   localparam logic [LENGTH_W-1:0]   LENGTH_RESET     = 9'd256;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE  = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

   // Everything of a queued item except the value word
   typedef struct packed {
      cmd_type                    cmd;
      logic [INDEX_W-1:0]         index;
      logic signed [GUESS_W-1:0]  guess;
   } item_meta_type;

   localparam int ITEM_META_W = $bits(item_meta_type);

endpackage

@@ src/sorted_table_hunt_search.sv @@
// Search of a monotone fixed-point table: write entries, then locate keys by
// galloping from a guess and bisecting. A write beat is stored in the table
// as it leaves the queue. A search beat reads the table through a single
// registered read port, one entry per cycle: the first and last entries, then,
// after the key is classified, one entry per hunt step and per bisection
// step; it then loads the result register, which waits while the result
// channel stalls. A two-beat queue lets requests arrive while the engine works.
// Depends on sth_pkg, sth_front, sth_queue and sth_engine.
module sorted_table_hunt_search
   import sth_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  cmd_type                       req_cmd,
   input  logic [INDEX_W-1:0]            req_entry_index,
   input  logic signed [FIELD_W-1:0]     req_entry_value,
   input  logic signed [FIELD_W-1:0]     req_search_key,
   input  logic signed [GUESS_W-1:0]     req_start_guess,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [RESULT_W-1:0]    rsp_found_index,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [CSR_DATA_W-1:0]         csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);

   localparam int QW = ITEM_META_W + VALUE_WIDTH;

   logic [LENGTH_W-1:0] length_ff;
   logic                csr_sel_len;
   logic                q_push, q_full, q_pop, q_empty;
   logic [QW-1:0]       push_item, pop_item;

   // Configuration register
   assign csr_pready  = 1'b1;
   assign csr_sel_len = (csr_paddr[CSR_ADDR_W-1:2] == CSR_TABLE_LENGTH);
   assign csr_prdata  = csr_sel_len ? CSR_DATA_W'(length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LENGTH_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_sel_len) begin
         length_ff <= csr_pwdata[LENGTH_W-1:0];
      end
   end

   sth_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .req_start_guess (req_start_guess),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (push_item)
   );

   sth_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_item),
      .empty     (q_empty)
   );

   sth_engine #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .table_length    (length_ff),
      .q_empty         (q_empty),
      .q_item          (pop_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found_index (rsp_found_index)
   );

endmodule

@@ src/sth_queue.sv @@
// Small first-in first-out queue that decouples the front from the engine.
// Depends on sth_pkg for the queue depth.
module sth_queue
   import sth_pkg::*;
#(
   parameter int WIDTH = 51
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ src/sth_front.sv @@
// Input side: accepts request beats, classifies them and packs queue items.
// Depends on sth_pkg for the item layout and command codes.
module sth_front
   import sth_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                              req_valid,
   output logic                              req_stall,
   input  cmd_type                           req_cmd,
   input  logic [INDEX_W-1:0]                req_entry_index,
   input  logic signed [FIELD_W-1:0]         req_entry_value,
   input  logic signed [FIELD_W-1:0]         req_search_key,
   input  logic signed [GUESS_W-1:0]         req_start_guess,
   input  logic                              q_full,
   output logic                              q_push,
   output logic [ITEM_META_W+VALUE_WIDTH-1:0] q_item
);

   item_meta_type                   meta;
   logic signed [FIELD_W-1:0]       value_sel;
   logic signed [VALUE_WIDTH-1:0]   value_cvt;

   // Hold the request while the queue is full
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // Pick the word the item carries and bring it to table width
   always_comb begin
      value_sel  = (req_cmd == CMD_WRITE) ? req_entry_value : req_search_key;
      value_cvt  = VALUE_WIDTH'(value_sel);
      meta.cmd   = req_cmd;
      meta.index = req_entry_index;
      meta.guess = req_start_guess;
   end

   assign q_item = {meta, value_cvt};

endmodule

@@ src/sth_engine.sv @@
// Back end: table memory, hunt/bisection sequencer and result register.
// Depends on sth_pkg for the item layout, command codes and field widths.
module sth_engine
   import sth_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [LENGTH_W-1:0]                table_length,
   input  logic                               q_empty,
   input  logic [ITEM_META_W+VALUE_WIDTH-1:0] q_item,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [RESULT_W-1:0]         rsp_found_index
);

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int SW_A = $clog2(TABLE_DEPTH + 1) + 3;
   localparam int SW   = (SW_A > GUESS_W + 1) ? SW_A : GUESS_W + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_LAST,
      S_GUESS,
      S_UP,
      S_DOWN,
      S_BIS,
      S_EMIT
   } state_type;

   typedef logic signed [SW-1:0]          idx_type;
   typedef logic signed [VALUE_WIDTH-1:0] val_type;

   // Table memory
   val_type   table_mem_ff [TABLE_DEPTH];
   val_type   rd_data_ff;
   logic      mem_we;
   logic [AW-1:0] mem_wa;
   idx_type   rd_idx;

   // Sequencer
   state_type state_ff, state_in;
   idx_type   lo_ff, lo_in, hi_ff, hi_in, inc_ff, inc_in, mid_ff, mid_in;
   idx_type   result_ff, result_in;
   val_type   key_ff, key_in, first_ff, first_in, last_ff, last_in;
   logic      asc_ff, asc_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_W-1:0] rsp_index_ff, rsp_index_in;

   item_meta_type meta;
   val_type       item_value;
   idx_type       len_ext, n_len, last_idx, inc_dbl, hi_new, lo_new;
   logic          reach, asc_now, out_free;

   assign meta       = q_item[ITEM_META_W+VALUE_WIDTH-1:VALUE_WIDTH];
   assign item_value = q_item[VALUE_WIDTH-1:0];

   // Clamp the configured length to the table
   assign len_ext  = $signed(SW'(table_length));
   assign n_len    = (len_ext < idx_type'(2)) ? idx_type'(2) :
                     (len_ext > idx_type'(TABLE_DEPTH)) ? idx_type'(TABLE_DEPTH) : len_ext;
   assign last_idx = n_len - idx_type'(1);

   // Key reaches the entry just read, in table order
   assign reach   = asc_ff ? (key_ff >= rd_data_ff) : (key_ff < rd_data_ff);
   assign asc_now = rd_data_ff > first_ff;
   assign inc_dbl = inc_ff <<< 1;
   assign hi_new  = hi_ff + inc_dbl;
   assign lo_new  = lo_ff - inc_dbl;
   assign mem_wa  = AW'(meta.index);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and datapath
   always_comb begin
      logic             go_bis;
      logic             finish;
      idx_type          bis_lo, bis_hi, fin_val;
      logic signed [SW:0] mid_sum;

      go_bis       = 1'b0;
      finish       = 1'b0;
      bis_lo       = lo_ff;
      bis_hi       = hi_ff;
      fin_val      = lo_ff;
      mid_sum      = '0;
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      inc_in       = inc_ff;
      mid_in       = mid_ff;
      result_in    = result_ff;
      key_in       = key_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      asc_in       = asc_ff;
      rd_idx       = '0;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (meta.cmd == CMD_WRITE) begin
                  mem_we = (32'(meta.index) < 32'(TABLE_DEPTH));
               end else begin
                  key_in   = item_value;
                  lo_in    = idx_type'(meta.guess);
                  rd_idx   = '0;
                  state_in = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            first_in = rd_data_ff;
            rd_idx   = last_idx;
            state_in = S_LAST;
         end
         S_LAST: begin
            // Classify: flat, below, beyond, guess outside, or hunt
            last_in = rd_data_ff;
            asc_in  = asc_now;
            if (!asc_now && (rd_data_ff == first_ff)) begin
               finish  = 1'b1;
               fin_val = idx_type'(-1);
            end else if ((asc_now && key_ff < first_ff) || (!asc_now && key_ff > first_ff)) begin
               finish  = 1'b1;
               fin_val = idx_type'(-1);
            end else if ((asc_now && key_ff > rd_data_ff) ||
                         (!asc_now && key_ff < rd_data_ff)) begin
               finish  = 1'b1;
               fin_val = n_len;
            end else if (lo_ff[SW-1] || (lo_ff > last_idx)) begin
               go_bis = 1'b1;
               bis_lo = idx_type'(-1);
               bis_hi = n_len;
            end else begin
               rd_idx   = lo_ff;
               state_in = S_GUESS;
            end
         end
         S_GUESS: begin
            inc_in = idx_type'(1);
            if (reach) begin
               if (lo_ff == last_idx) begin
                  finish  = 1'b1;
                  fin_val = (key_ff == last_ff) ? last_idx : n_len;
               end else begin
                  hi_in    = lo_ff + idx_type'(1);
                  rd_idx   = lo_ff + idx_type'(1);
                  state_in = S_UP;
               end
            end else begin
               if (lo_ff == '0) begin
                  finish  = 1'b1;
                  fin_val = idx_type'(-1);
               end else begin
                  hi_in    = lo_ff;
                  lo_in    = lo_ff - idx_type'(1);
                  rd_idx   = lo_ff - idx_type'(1);
                  state_in = S_DOWN;
               end
            end
         end
         S_UP: begin
            // Gallop upward with doubling steps
            if (reach) begin
               if (hi_new > last_idx) begin
                  go_bis = 1'b1;
                  bis_lo = hi_ff;
                  bis_hi = n_len;
               end else begin
                  lo_in  = hi_ff;
                  hi_in  = hi_new;
                  inc_in = inc_dbl;
                  rd_idx = hi_new;
               end
            end else begin
               go_bis = 1'b1;
            end
         end
         S_DOWN: begin
            // Gallop downward with doubling steps
            if (!reach) begin
               if (lo_new[SW-1]) begin
                  go_bis = 1'b1;
                  bis_lo = '0;
                  bis_hi = lo_ff;
               end else begin
                  hi_in  = lo_ff;
                  lo_in  = lo_new;
                  inc_in = inc_dbl;
                  rd_idx = lo_new;
               end
            end else begin
               go_bis = 1'b1;
            end
         end
         S_BIS: begin
            go_bis = 1'b1;
            if (reach) begin
               bis_lo = mid_ff;
            end else begin
               bis_hi = mid_ff;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = result_ff[RESULT_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Bisection step: read the midpoint or finish on the lower bound
      if (go_bis) begin
         if ((bis_hi - bis_lo) > idx_type'(1)) begin
            mid_sum  = {bis_lo[SW-1], bis_lo} + {bis_hi[SW-1], bis_hi};
            mid_in   = mid_sum[SW:1];
            lo_in    = bis_lo;
            hi_in    = bis_hi;
            rd_idx   = mid_sum[SW:1];
            state_in = S_BIS;
         end else begin
            finish  = 1'b1;
            fin_val = bis_lo;
         end
      end

      if (finish) begin
         result_in = fin_val;
         state_in  = S_EMIT;
      end
   end

   // Table memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem_ff[mem_wa] <= item_value;
      end
      rd_data_ff <= table_mem_ff[rd_idx[AW-1:0]];
   end

   // Sequencer state and result register
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      inc_ff       <= inc_in;
      mid_ff       <= mid_in;
      result_ff    <= result_in;
      key_ff       <= key_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      asc_ff       <= asc_in;
      rsp_index_ff <= rsp_index_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found_index = rsp_index_ff;

endmodule
